[rtl/oaids_pkg.sv]
package oaids_pkg;

    // Default list capacity.
    localparam int CAPACITY_DEFAULT = 64;

    // Field widths of the request and result transactions.
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int CNT_OUT_W = 7;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_SEARCH  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_POS = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_KEY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_POS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_KEY = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // Cell operations.
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic       load;       // capture the match flag against the new key
        logic [1:0] op;         // hold, shift up with insert, or shift down
        logic       use_match;  // select cells by the match flags, not by position
    } cell_cmd_t;

endpackage

[rtl/oaids_cell.sv]
module oaids_cell #(
    parameter int CAPACITY = oaids_pkg::CAPACITY_DEFAULT,
    parameter int IDX      = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  oaids_pkg::cell_cmd_t                  cmd,
    input  logic signed [oaids_pkg::DATA_W-1:0]   value,
    input  logic signed [oaids_pkg::DATA_W-1:0]   key,
    input  logic [$clog2(CAPACITY+1)-1:0]         count,
    input  logic [(($clog2(CAPACITY+1) > oaids_pkg::POS_W) ?
                   $clog2(CAPACITY+1) : oaids_pkg::POS_W):0] pos0,
    input  logic signed [oaids_pkg::DATA_W-1:0]   entry_lo,
    input  logic signed [oaids_pkg::DATA_W-1:0]   entry_hi,
    input  logic                                  match_hi,
    input  logic                                  sel_lo,
    input  logic                                  lower_match,
    output logic signed [oaids_pkg::DATA_W-1:0]   entry,
    output logic                                  match,
    output logic                                  sel
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > oaids_pkg::POS_W) ? CW : oaids_pkg::POS_W) + 1;

    logic signed [oaids_pkg::DATA_W-1:0] entry_reg;
    logic                                match_reg;
    logic                                in_list;

    // This cell holds a live entry when its slot lies below the count.
    assign in_list = ((CW + 1)'(IDX) < {1'b0, count});

    // A cell shifts when at or above the target slot or the lowest match.
    assign sel = cmd.use_match ? (lower_match | match_reg) : (XW'(IDX) >= pos0);

    // Entry and match flag, moved to or from the neighbors on a shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            match_reg <= in_list && (entry_reg == key);
        end
        else
        begin
            case (cmd.op)
                oaids_pkg::OP_INS:
                begin
                    if (sel)
                    begin
                        match_reg <= 1'b0;
                    end
                end
                oaids_pkg::OP_DEL:
                begin
                    if (sel)
                    begin
                        match_reg <= match_hi;
                    end
                end
                default:
                begin
                    match_reg <= match_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd.load)
        begin
            case (cmd.op)
                oaids_pkg::OP_INS:
                begin
                    if (sel)
                    begin
                        entry_reg <= sel_lo ? entry_lo : value;
                    end
                end
                oaids_pkg::OP_DEL:
                begin
                    if (sel)
                    begin
                        entry_reg <= entry_hi;
                    end
                end
                default:
                begin
                    entry_reg <= entry_reg;
                end
            endcase
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

[rtl/oaids_scan.sv]
module oaids_scan #(
    parameter int CAPACITY = oaids_pkg::CAPACITY_DEFAULT
) (
    input  logic [CAPACITY-1:0]             match_vec,
    output logic [CAPACITY-1:0]             before_vec,
    output logic                            any_match,
    output logic [$clog2(CAPACITY+1)-1:0]   first_pos
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Each cell learns whether any lower slot matches.
    assign before_vec[0] = 1'b0;
    for (genvar i = 1; i < CAPACITY; i++)
    begin : g_before
        assign before_vec[i] = |match_vec[i-1:0];
    end

    assign any_match = |match_vec;

    // Encode the single lowest match as a 1-based slot number.
    always_comb
    begin
        first_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i] && !before_vec[i])
            begin
                first_pos = first_pos | CW'(i + 1);
            end
        end
    end

endmodule

[rtl/ordered_array_insert_delete_search_core.sv]
// Channel  Direction  Payload (lowest bits first)
// s_axis   in         tuser: mode[2:0]; tdata: value[31:0], key[63:32], position[70:64]
// m_axis   out        tuser: status[1:0]; tdata: found_position[6:0],
//                     removed_count[13:7], length_after[20:14]
//
// The accept edge compares the key in every cell; in the execute state, once the
// result register is free, an edge applies the shift and writes the result register.
// Delete of every match removes one match per cycle through the cell row while the
// result register is free, until no match is left.
// Reset clears the count and the control state; the entries hold no reset value.
// A new request is taken while the previous result waits on m_axis; a request
// completes only once the result register is free.
module ordered_array_insert_delete_search_core #(
    parameter int CAPACITY = oaids_pkg::CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // value, key, position, zero pad
    input  logic [2:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // found_position, removed_count, length_after, zero pad
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > oaids_pkg::POS_W) ? CW : oaids_pkg::POS_W) + 1;
    localparam int DW = oaids_pkg::DATA_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Request fields.
    logic signed [DW-1:0]            in_value;
    logic signed [DW-1:0]            in_key;
    logic [oaids_pkg::POS_W-1:0]     in_pos;
    logic [oaids_pkg::MODE_W-1:0]    in_mode;

    assign in_value = s_axis_tdata[31:0];
    assign in_key   = s_axis_tdata[63:32];
    assign in_pos   = s_axis_tdata[70:64];
    assign in_mode  = s_axis_tuser;

    // Control and request registers.
    logic                            state_reg,   state_next;
    logic [oaids_pkg::MODE_W-1:0]    mode_reg;
    logic signed [DW-1:0]            value_reg;
    logic [oaids_pkg::POS_W-1:0]     pos_reg;
    logic [CW-1:0]                   count_reg,   count_next;
    logic [CW-1:0]                   removed_reg, removed_next;
    logic [CW-1:0]                   found_reg,   found_next;
    logic                            first_reg,   first_next;

    // Result register.
    logic                            out_valid_reg;
    logic [oaids_pkg::STATUS_W-1:0]  status_out_reg;
    logic [CW-1:0]                   found_out_reg;
    logic [CW-1:0]                   removed_out_reg;
    logic [CW-1:0]                   length_out_reg;

    logic                            accept;
    logic                            stall;
    logic                            finish;
    logic [oaids_pkg::STATUS_W-1:0]  status_res;
    logic [CW-1:0]                   found_res;
    oaids_pkg::cell_cmd_t            cmd;

    logic [XW-1:0]                   pos_x;
    logic [XW-1:0]                   cnt_x;
    logic [XW-1:0]                   pos0;
    logic                            full;
    logic                            ins_ok;
    logic                            del_ok;

    // Cell row wiring.
    logic signed [DW-1:0]            entry_w [CAPACITY];
    logic [CAPACITY-1:0]             match_vec;
    logic [CAPACITY-1:0]             sel_vec;
    logic [CAPACITY-1:0]             before_vec;
    logic                            any_match;
    logic [CW-1:0]                   first_pos;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign stall = out_valid_reg && !m_axis_tready;

    // Position range checks against the current length.
    assign pos_x  = XW'(pos_reg);
    assign cnt_x  = XW'(count_reg);
    assign pos0   = pos_x - XW'(1);
    assign full   = (count_reg == CW'(CAPACITY));
    assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
    assign del_ok = (pos_x != '0) && (pos_x <= cnt_x);

    // Sequencer: decide the cell command and the result of the request.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        found_next   = found_reg;
        first_next   = first_reg;
        finish       = 1'b0;
        status_res   = oaids_pkg::ST_OK;
        found_res    = '0;
        cmd.load      = 1'b0;
        cmd.op        = oaids_pkg::OP_HOLD;
        cmd.use_match = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load     = 1'b1;
                    removed_next = '0;
                    first_next   = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stall)
                begin
                    unique case (mode_reg)
                        oaids_pkg::MODE_SEARCH:
                        begin
                            finish    = 1'b1;
                            found_res = first_pos;
                            status_res = any_match ? oaids_pkg::ST_OK : oaids_pkg::ST_NOTFOUND;
                        end
                        oaids_pkg::MODE_INS_POS:
                        begin
                            finish = 1'b1;
                            if (!ins_ok)
                            begin
                                status_res = oaids_pkg::ST_BADPOS;
                            end
                            else if (full)
                            begin
                                status_res = oaids_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = oaids_pkg::OP_INS;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        oaids_pkg::MODE_INS_KEY:
                        begin
                            finish    = 1'b1;
                            found_res = first_pos;
                            if (!any_match)
                            begin
                                status_res = oaids_pkg::ST_NOTFOUND;
                            end
                            else if (full)
                            begin
                                status_res = oaids_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op        = oaids_pkg::OP_INS;
                                cmd.use_match = 1'b1;
                                count_next    = count_reg + CW'(1);
                            end
                        end
                        oaids_pkg::MODE_DEL_POS:
                        begin
                            finish = 1'b1;
                            if (!del_ok)
                            begin
                                status_res = oaids_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                cmd.op       = oaids_pkg::OP_DEL;
                                count_next   = count_reg - CW'(1);
                                removed_next = CW'(1);
                            end
                        end
                        oaids_pkg::MODE_DEL_KEY:
                        begin
                            // The first step records the lowest match before any removal.
                            first_next = 1'b0;
                            if (first_reg)
                            begin
                                found_next = first_pos;
                            end
                            if (any_match)
                            begin
                                cmd.op        = oaids_pkg::OP_DEL;
                                cmd.use_match = 1'b1;
                                count_next    = count_reg - CW'(1);
                                removed_next  = removed_reg + CW'(1);
                            end
                            else
                            begin
                                finish     = 1'b1;
                                found_res  = first_reg ? first_pos : found_reg;
                                status_res = (removed_reg == '0) ? oaids_pkg::ST_NOTFOUND
                                                                 : oaids_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                    if (finish)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            removed_reg   <= '0;
            found_reg     <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            removed_reg <= removed_next;
            found_reg   <= found_next;
            first_reg   <= first_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= in_mode;
            value_reg <= in_value;
            pos_reg   <= in_pos;
        end
        if (finish)
        begin
            status_out_reg  <= status_res;
            found_out_reg   <= found_res;
            removed_out_reg <= removed_next;
            length_out_reg  <= count_next;
        end
    end

    // Row of storage cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DW-1:0] lo_entry;
        logic signed [DW-1:0] hi_entry;
        logic                 hi_match;
        logic                 lo_sel;

        if (i == 0)
        begin : g_first
            assign lo_entry = '0;
            assign lo_sel   = 1'b0;
        end
        else
        begin : g_mid_lo
            assign lo_entry = entry_w[i-1];
            assign lo_sel   = sel_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign hi_entry = '0;
            assign hi_match = 1'b0;
        end
        else
        begin : g_mid_hi
            assign hi_entry = entry_w[i+1];
            assign hi_match = match_vec[i+1];
        end

        oaids_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .value       (value_reg),
            .key         (in_key),
            .count       (count_reg),
            .pos0        (pos0),
            .entry_lo    (lo_entry),
            .entry_hi    (hi_entry),
            .match_hi    (hi_match),
            .sel_lo      (lo_sel),
            .lower_match (before_vec[i]),
            .entry       (entry_w[i]),
            .match       (match_vec[i]),
            .sel         (sel_vec[i])
        );
    end

    // Lowest match and per-cell prefix flags.
    oaids_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .match_vec  (match_vec),
        .before_vec (before_vec),
        .any_match  (any_match),
        .first_pos  (first_pos)
    );

    // Result transaction.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_out_reg;
    assign m_axis_tdata  = {3'b000,
                            oaids_pkg::CNT_OUT_W'(length_out_reg),
                            oaids_pkg::CNT_OUT_W'(removed_out_reg),
                            oaids_pkg::CNT_OUT_W'(found_out_reg)};

    // The length never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} <= (CW + 1)'(CAPACITY)))
        else $error("entry count above capacity");

    // An accepted request puts the core in the execute state in the next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed");

    // The length moves by at most one entry per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg == $past(count_reg) - CW'(1))))
        else $error("entry count jumped");

    // Delete of every match completes once no match is left.
    a_delkey_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && (mode_reg == oaids_pkg::MODE_DEL_KEY) &&
         !any_match && !stall) |=> (m_axis_tvalid && (state_reg == ST_IDLE)))
        else $error("delete of matches did not complete");

endmodule
